// ===== src/ffsa_pkg.sv =====
// Shared types and constants of the first-fit segment allocator.
`default_nettype none

package ffsa_pkg;

    // Operation codes carried in the opcode field.
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_STATS = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NOFIT    = 2'd1;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POOL_SIZE     = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEADER_MARGIN = 4'd1;

    // Register values after reset.
    localparam logic [15:0] POOL_SIZE_RESET     = 16'd65535;
    localparam logic [7:0]  HEADER_MARGIN_RESET = 8'd24;

    // One request transaction.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] request_size;
        logic [15:0] release_offset;
    } ffsa_in_t;

    // One result transaction.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] block_offset;
        logic [5:0]  used_count;
        logic [15:0] allocated_total;
        logic [15:0] free_total;
        logic [15:0] peak_free;
        logic [5:0]  free_count;
    } ffsa_out_t;

    // Configuration handed from the register block to the controller.
    typedef struct packed {
        logic [15:0] pool_size;
        logic [7:0]  header_margin;
        logic        restart;
    } ffsa_cfg_t;

endpackage

`default_nettype wire

// ===== src/ffsa_seg_mem.sv =====
// Segment table memory: one write port, one read port with registered data.
`default_nettype none

module ffsa_seg_mem #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/ffsa_ctrl.sv =====
// Chain walker: reads segment entries, applies allocate, free or statistics, writes back.
`default_nettype none

module ffsa_ctrl import ffsa_pkg::*; #(
    parameter int MAX_SEGMENTS = 32,
    parameter int OFFSET_BITS  = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire ffsa_cfg_t cfg,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire ffsa_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output ffsa_out_t      m_data,
    output logic [$clog2(MAX_SEGMENTS)-1:0] mem_rd_addr,
    input  wire logic [OFFSET_BITS + ((OFFSET_BITS < 16) ? OFFSET_BITS : 16) + 1
                       + $clog2(MAX_SEGMENTS + 1) - 1:0] mem_rd_data,
    output logic           mem_wr_en,
    output logic [$clog2(MAX_SEGMENTS)-1:0] mem_wr_addr,
    output logic [OFFSET_BITS + ((OFFSET_BITS < 16) ? OFFSET_BITS : 16) + 1
                  + $clog2(MAX_SEGMENTS + 1) - 1:0] mem_wr_data
);

    localparam int IDX_BITS  = $clog2(MAX_SEGMENTS);
    localparam int LINK_BITS = $clog2(MAX_SEGMENTS + 1);
    localparam int SIZE_BITS = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;
    localparam int CMP_BITS  = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
    localparam logic [LINK_BITS-1:0] END_MARK  = LINK_BITS'(MAX_SEGMENTS);
    localparam logic [LINK_BITS-1:0] MAX_STEPS = LINK_BITS'(MAX_SEGMENTS);

    // Controller states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_SPLIT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] start;
        logic [SIZE_BITS-1:0]   size;
        logic                   used;
        logic [LINK_BITS-1:0]   link;
    } seg_entry_t;

    // Control registers.
    logic [1:0]           state_reg, state_next;
    logic [LINK_BITS-1:0] count_reg, count_next;
    logic                 fresh_reg, fresh_next;
    logic                 m_valid_reg, m_valid_next;

    // Payload registers.
    logic [1:0]           op_reg, op_next;
    logic [SIZE_BITS-1:0] req_reg, req_next;
    logic [15:0]          rel_reg, rel_next;
    logic [IDX_BITS-1:0]  idx_reg, idx_next;
    logic [LINK_BITS-1:0] steps_reg, steps_next;
    logic [1:0]           status_reg, status_next;
    logic [15:0]          offs_reg, offs_next;
    logic [5:0]           ucnt_reg, ucnt_next;
    logic [5:0]           fcnt_reg, fcnt_next;
    logic [15:0]          utot_reg, utot_next;
    logic [15:0]          ftot_reg, ftot_next;
    logic [15:0]          large_reg, large_next;
    seg_entry_t           split_entry_reg, split_entry_next;
    logic [IDX_BITS-1:0]  split_addr_reg, split_addr_next;
    ffsa_out_t            m_data_reg, m_data_next;

    seg_entry_t           rd_entry;
    seg_entry_t           cur;
    seg_entry_t           wr_entry;
    logic                 fit;
    logic                 room;
    logic                 split;
    logic                 hit;
    logic                 more;
    logic [LINK_BITS-1:0] steps_inc;

    assign rd_entry = seg_entry_t'(mem_rd_data);

    // Entry zero reads as one free segment of the pool size until it is written.
    always_comb begin
        if (fresh_reg && (idx_reg == '0)) begin
            cur.start = '0;
            cur.size  = cfg.pool_size[SIZE_BITS-1:0];
            cur.used  = 1'b0;
            cur.link  = END_MARK;
        end else begin
            cur = rd_entry;
        end
    end

    // Decisions on the entry now at the read port.
    assign fit       = !cur.used && (cur.size >= req_reg);
    assign room      = count_reg < LINK_BITS'(MAX_SEGMENTS);
    assign split     = (17'(cur.size) > (17'(req_reg) + 17'(cfg.header_margin))) && room;
    assign hit       = cur.used && (CMP_BITS'(cur.start) == CMP_BITS'(rel_reg));
    assign steps_inc = steps_reg + 1'b1;
    assign more      = (cur.link < END_MARK) && (steps_inc < MAX_STEPS);

    // Next-state and memory access logic.
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        fresh_next       = fresh_reg;
        m_valid_next     = m_valid_reg;
        op_next          = op_reg;
        req_next         = req_reg;
        rel_next         = rel_reg;
        idx_next         = idx_reg;
        steps_next       = steps_reg;
        status_next      = status_reg;
        offs_next        = offs_reg;
        ucnt_next        = ucnt_reg;
        fcnt_next        = fcnt_reg;
        utot_next        = utot_reg;
        ftot_next        = ftot_reg;
        large_next       = large_reg;
        split_entry_next = split_entry_reg;
        split_addr_next  = split_addr_reg;
        m_data_next      = m_data_reg;
        mem_rd_addr      = '0;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = idx_reg;
        wr_entry         = cur;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data.opcode;
                    req_next   = s_data.request_size[SIZE_BITS-1:0];
                    rel_next   = s_data.release_offset;
                    idx_next   = '0;
                    steps_next = '0;
                    offs_next  = '0;
                    ucnt_next  = '0;
                    fcnt_next  = '0;
                    utot_next  = '0;
                    ftot_next  = '0;
                    large_next = '0;
                    case (s_data.opcode)
                        OP_ALLOC: begin
                            status_next = STATUS_NOFIT;
                            state_next  = S_EVAL;
                        end
                        OP_FREE: begin
                            status_next = STATUS_NOTFOUND;
                            state_next  = S_EVAL;
                        end
                        OP_STATS: begin
                            status_next = STATUS_OK;
                            state_next  = S_EVAL;
                        end
                        default: begin
                            status_next = STATUS_OK;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_EVAL: begin
                // Follow the link unless this entry ends the operation.
                idx_next    = cur.link[IDX_BITS-1:0];
                steps_next  = steps_inc;
                mem_rd_addr = cur.link[IDX_BITS-1:0];
                state_next  = more ? S_EVAL : S_DONE;
                case (op_reg)
                    OP_ALLOC: begin
                        if (fit) begin
                            status_next    = STATUS_OK;
                            offs_next      = 16'(CMP_BITS'(cur.start));
                            mem_wr_en      = 1'b1;
                            wr_entry.used  = 1'b1;
                            if (split) begin
                                wr_entry.size          = req_reg;
                                wr_entry.link          = count_reg;
                                split_entry_next.start = cur.start + OFFSET_BITS'(req_reg);
                                split_entry_next.size  = cur.size - req_reg;
                                split_entry_next.used  = 1'b0;
                                split_entry_next.link  = cur.link;
                                split_addr_next        = count_reg[IDX_BITS-1:0];
                                count_next             = count_reg + 1'b1;
                                state_next             = S_SPLIT;
                            end else begin
                                state_next = S_DONE;
                            end
                        end
                    end
                    OP_FREE: begin
                        if (hit) begin
                            status_next   = STATUS_OK;
                            mem_wr_en     = 1'b1;
                            wr_entry.used = 1'b0;
                            state_next    = S_DONE;
                        end
                    end
                    OP_STATS: begin
                        if (cur.used) begin
                            ucnt_next = ucnt_reg + 1'b1;
                            utot_next = utot_reg + 16'(cur.size);
                        end else begin
                            fcnt_next = fcnt_reg + 1'b1;
                            ftot_next = ftot_reg + 16'(cur.size);
                            if (16'(cur.size) > large_reg) begin
                                large_next = 16'(cur.size);
                            end
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SPLIT: begin
                // Second write of a split: the free remainder.
                mem_wr_en   = 1'b1;
                mem_wr_addr = split_addr_reg;
                wr_entry    = split_entry_reg;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.status          = status_reg;
                    m_data_next.block_offset    = offs_reg;
                    m_data_next.used_count      = ucnt_reg;
                    m_data_next.allocated_total = utot_reg;
                    m_data_next.free_total      = ftot_reg;
                    m_data_next.peak_free       = large_reg;
                    m_data_next.free_count      = fcnt_reg;
                    state_next                  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Once entry zero is written, the memory holds its real value.
        if (mem_wr_en && (mem_wr_addr == '0)) begin
            fresh_next = 1'b0;
        end

        // A pool size write restarts the table as one free segment.
        if (cfg.restart) begin
            count_next = LINK_BITS'(1);
            fresh_next = 1'b1;
        end
    end

    assign mem_wr_data = wr_entry;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= LINK_BITS'(1);
            fresh_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            fresh_reg   <= fresh_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload state.
    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        req_reg         <= req_next;
        rel_reg         <= rel_next;
        idx_reg         <= idx_next;
        steps_reg       <= steps_next;
        status_reg      <= status_next;
        offs_reg        <= offs_next;
        ucnt_reg        <= ucnt_next;
        fcnt_reg        <= fcnt_next;
        utot_reg        <= utot_next;
        ftot_reg        <= ftot_next;
        large_reg       <= large_next;
        split_entry_reg <= split_entry_next;
        split_addr_reg  <= split_addr_next;
        m_data_reg      <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== src/first_fit_segment_allocator_unit.sv =====
// Top level of the first-fit segment allocator: registers, controller and table memory.
//
// Requests arrive on the s_ channel (valid/ready) as an opcode with a request size
// or a release offset; each request produces exactly one result transaction on the
// m_ channel. Allocate walks the segment chain to the first free segment that fits,
// free walks it to the used segment at the given offset, statistics walks all of it.
// The chain is read from the segment table memory one entry per cycle; after the walk the
// result is registered in S_DONE, preceded by S_SPLIT when an allocation splits its
// segment (one more table write). The next request is taken once the controller is
// back in idle; an unknown opcode visits no entry. The worst case is a walk of all
// MAX_SEGMENTS entries, which only happens on a full table where no split is made.
// One request is in work at a time; s_ready is high while the controller is idle,
// also while a result still waits in the output register. If the receiver stalls,
// the finished result is held and the next request waits in its last step until
// the output register frees.
// Reset (aresetn low, synchronous) returns pool_size to 65535 and header_margin to
// 24, and the table to one free segment covering the pool; no clearing pass is made.
// A write to pool_size restarts the table the same way.
`default_nettype none

module first_fit_segment_allocator_unit import ffsa_pkg::*; #(
    parameter int MAX_SEGMENTS = 32,
    parameter int OFFSET_BITS  = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire ffsa_in_t                  s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output ffsa_out_t                      m_data
);

    localparam int IDX_BITS   = $clog2(MAX_SEGMENTS);
    localparam int LINK_BITS  = $clog2(MAX_SEGMENTS + 1);
    localparam int SIZE_BITS  = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;
    localparam int ENTRY_BITS = OFFSET_BITS + SIZE_BITS + 1 + LINK_BITS;

    logic [15:0]           pool_size_reg, pool_size_next;
    logic [7:0]            margin_reg, margin_next;
    ffsa_cfg_t             cfg;
    logic [IDX_BITS-1:0]   mem_rd_addr;
    logic [ENTRY_BITS-1:0] mem_rd_data;
    logic                  mem_wr_en;
    logic [IDX_BITS-1:0]   mem_wr_addr;
    logic [ENTRY_BITS-1:0] mem_wr_data;

    // Configuration register writes.
    always_comb begin
        pool_size_next = pool_size_reg;
        margin_next    = margin_reg;
        if (cfg_we && (cfg_index == REG_POOL_SIZE)) begin
            pool_size_next = cfg_wdata[15:0];
        end
        if (cfg_we && (cfg_index == REG_HEADER_MARGIN)) begin
            margin_next = cfg_wdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_size_reg <= POOL_SIZE_RESET;
            margin_reg    <= HEADER_MARGIN_RESET;
        end else begin
            pool_size_reg <= pool_size_next;
            margin_reg    <= margin_next;
        end
    end

    assign cfg.pool_size     = pool_size_reg;
    assign cfg.header_margin = margin_reg;
    assign cfg.restart       = cfg_we && (cfg_index == REG_POOL_SIZE);

    // Chain walker.
    ffsa_ctrl #(
        .MAX_SEGMENTS(MAX_SEGMENTS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mem_rd_addr(mem_rd_addr),
        .mem_rd_data(mem_rd_data),
        .mem_wr_en  (mem_wr_en),
        .mem_wr_addr(mem_wr_addr),
        .mem_wr_data(mem_wr_data)
    );

    // Segment table.
    ffsa_seg_mem #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(MAX_SEGMENTS)
    ) u_mem (
        .aclk   (aclk),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data)
    );

endmodule

`default_nettype wire

// ===== src/ffsa_checker.sv =====
// Port-level checks of the first-fit segment allocator and their binding to the top level.
`default_nettype none

module ffsa_checker import ffsa_pkg::*; (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire ffsa_out_t m_data
);

    // A stalled result stays offered.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn while stalled");

    // One request at a time: the input closes right after a transaction.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request accepted while one is in work");

    // A failed request reports no offset and no statistics.
    a_fail_is_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != STATUS_OK) |->
            (m_data.block_offset == '0) && (m_data.used_count == '0) &&
            (m_data.free_count == '0) && (m_data.free_total == '0))
        else $error("failed request carries data");

    // Statistics fields come only with a good status and no offset.
    a_stats_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_data.used_count != '0) || (m_data.free_count != '0)) |->
            (m_data.status == STATUS_OK) && (m_data.block_offset == '0))
        else $error("statistics mixed with an allocation result");

endmodule

bind first_fit_segment_allocator_unit ffsa_checker u_ffsa_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

`default_nettype wire
